/* rtl/core/qse_pkg.sv */
// qse_pkg: shared types and constants of the quicksort engine.
// No dependencies; imported by qse_seq and the top level.
package qse_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_EW = IDX_W + 1;
    localparam int VAL_W  = 32;
    localparam int RNG_W  = 2 * IDX_W;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } qse_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    end_of_run;
        logic                    overflow;
    } qse_out_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
    } qse_mem_ctl_t;

endpackage

/* rtl/core/qse_ram.sv */
// qse_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the element store and the range stack.
module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/qse_seq.sv */
// qse_seq: load, partition and emit sequencer with the shared comparator.
// Depends on qse_pkg; drives the store and stack RAMs built by the top level.
module qse_seq
    import qse_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qse_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qse_out_t           m_data,
    output qse_mem_ctl_t       st_ctl,
    output logic [VAL_W-1:0]   st_wdata,
    input  logic [VAL_W-1:0]   st_rdata,
    output qse_mem_ctl_t       sk_ctl,
    output logic [RNG_W-1:0]   sk_wdata,
    input  logic [RNG_W-1:0]   sk_rdata
);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_SEED   = 20'h00002,
        ST_POP    = 20'h00004,
        ST_POP_LD = 20'h00008,
        ST_PIV_RD = 20'h00010,
        ST_PIV_LD = 20'h00020,
        ST_CHECK  = 20'h00040,
        ST_LSCAN  = 20'h00080,
        ST_LCMP   = 20'h00100,
        ST_RSCAN  = 20'h00200,
        ST_RCMP   = 20'h00400,
        ST_SWAP1  = 20'h00800,
        ST_SWAP2  = 20'h01000,
        ST_FIN1   = 20'h02000,
        ST_FIN2   = 20'h04000,
        ST_PUSH_A = 20'h08000,
        ST_PUSH_B = 20'h10000,
        ST_EM_RD  = 20'h20000,
        ST_EM_LD  = 20'h40000,
        ST_EM_WT  = 20'h80000
    } qse_state_t;

    qse_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    dropped_reg, dropped_next;
    logic [CNT_W-1:0]        sp_reg, sp_next;
    logic [IDX_W-1:0]        lo_reg, lo_next;
    logic [IDX_W-1:0]        hi_reg, hi_next;
    logic [IDX_W-1:0]        left_reg, left_next;
    logic [IDX_W-1:0]        right_reg, right_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic signed [VAL_W-1:0] pivot_reg, pivot_next;
    logic signed [VAL_W-1:0] lval_reg, lval_next;
    logic signed [VAL_W-1:0] rval_reg, rval_next;
    qse_out_t                out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    le_pivot;
    logic                    stack_room;
    logic [IDX_W-1:0]        pop_lo, pop_hi;
    logic                    em_end;

    // single shared comparator
    assign le_pivot   = $signed(st_rdata) <= pivot_reg;
    assign stack_room = sp_reg < CNT_W'(DEPTH);
    assign pop_lo     = sk_rdata[RNG_W-1:IDX_W];
    assign pop_hi     = sk_rdata[IDX_W-1:0];
    assign em_end     = (IDX_EW'(k_reg) + IDX_EW'(1)) == IDX_EW'(count_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        sp_next        = sp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        k_next         = k_reg;
        pivot_next     = pivot_reg;
        lval_next      = lval_reg;
        rval_next      = rval_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        st_ctl         = '0;
        st_wdata       = rval_reg;
        sk_ctl         = '0;
        sk_wdata       = {lo_reg, IDX_W'(right_reg - 1'b1)};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (count_reg < CNT_W'(DEPTH)) begin
                        st_ctl.we    = 1'b1;
                        st_ctl.waddr = count_reg[IDX_W-1:0];
                        st_wdata     = s_data.value;
                        count_next   = CNT_W'(count_reg + 1'b1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_data.last) begin
                        state_next = ST_SEED;
                    end
                end
            end
            ST_SEED: begin
                sp_next = '0;
                if (count_reg > CNT_W'(1)) begin
                    sk_ctl.we    = 1'b1;
                    sk_ctl.waddr = '0;
                    sk_wdata     = {IDX_W'(0), IDX_W'(count_reg - 1'b1)};
                    sp_next      = CNT_W'(1);
                end
                state_next = ST_POP;
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    k_next     = '0;
                    state_next = ST_EM_RD;
                end else begin
                    sk_ctl.raddr = IDX_W'(sp_reg - 1'b1);
                    sp_next      = CNT_W'(sp_reg - 1'b1);
                    state_next   = ST_POP_LD;
                end
            end
            ST_POP_LD: begin
                lo_next    = pop_lo;
                hi_next    = pop_hi;
                left_next  = pop_lo;
                right_next = pop_hi;
                if ((pop_lo >= pop_hi) || (IDX_EW'(pop_hi) >= IDX_EW'(count_reg))) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_PIV_RD;
                end
            end
            ST_PIV_RD: begin
                st_ctl.raddr = lo_reg;
                state_next   = ST_PIV_LD;
            end
            ST_PIV_LD: begin
                pivot_next = $signed(st_rdata);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = (left_reg < right_reg) ? ST_LSCAN : ST_FIN1;
            end
            ST_LSCAN: begin
                st_ctl.raddr = left_reg;
                state_next   = ST_LCMP;
            end
            ST_LCMP: begin
                lval_next = $signed(st_rdata);
                if (le_pivot && (left_reg < hi_reg)) begin
                    left_next  = IDX_W'(left_reg + 1'b1);
                    state_next = ST_LSCAN;
                end else begin
                    state_next = ST_RSCAN;
                end
            end
            ST_RSCAN: begin
                st_ctl.raddr = right_reg;
                state_next   = ST_RCMP;
            end
            ST_RCMP: begin
                rval_next = $signed(st_rdata);
                if (!le_pivot) begin
                    right_next = IDX_W'(right_reg - 1'b1);
                    state_next = ST_RSCAN;
                end else if (left_reg < right_reg) begin
                    state_next = ST_SWAP1;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_SWAP1: begin
                st_ctl.we    = 1'b1;
                st_ctl.waddr = left_reg;
                st_wdata     = rval_reg;
                state_next   = ST_SWAP2;
            end
            ST_SWAP2: begin
                st_ctl.we    = 1'b1;
                st_ctl.waddr = right_reg;
                st_wdata     = lval_reg;
                state_next   = ST_CHECK;
            end
            ST_FIN1: begin
                st_ctl.we    = 1'b1;
                st_ctl.waddr = lo_reg;
                st_wdata     = rval_reg;
                state_next   = ST_FIN2;
            end
            ST_FIN2: begin
                st_ctl.we    = 1'b1;
                st_ctl.waddr = right_reg;
                st_wdata     = pivot_reg;
                state_next   = ST_PUSH_A;
            end
            ST_PUSH_A: begin
                // left part: lo .. p-1
                if ((IDX_EW'(right_reg) > IDX_EW'(lo_reg) + IDX_EW'(1)) && stack_room) begin
                    sk_ctl.we    = 1'b1;
                    sk_ctl.waddr = sp_reg[IDX_W-1:0];
                    sk_wdata     = {lo_reg, IDX_W'(right_reg - 1'b1)};
                    sp_next      = CNT_W'(sp_reg + 1'b1);
                end
                state_next = ST_PUSH_B;
            end
            ST_PUSH_B: begin
                // right part: p+1 .. hi
                if ((IDX_EW'(hi_reg) > IDX_EW'(right_reg) + IDX_EW'(1)) && stack_room) begin
                    sk_ctl.we    = 1'b1;
                    sk_ctl.waddr = sp_reg[IDX_W-1:0];
                    sk_wdata     = {IDX_W'(right_reg + 1'b1), hi_reg};
                    sp_next      = CNT_W'(sp_reg + 1'b1);
                end
                state_next = ST_POP;
            end
            ST_EM_RD: begin
                st_ctl.raddr = k_reg;
                state_next   = ST_EM_LD;
            end
            ST_EM_LD: begin
                out_next.sorted_value = $signed(st_rdata);
                out_next.end_of_run   = em_end;
                out_next.overflow     = dropped_reg;
                out_valid_next        = 1'b1;
                state_next            = ST_EM_WT;
            end
            ST_EM_WT: begin
                if (m_ready) begin
                    out_valid_next = 1'b0;
                    if (out_reg.end_of_run) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        k_next     = IDX_W'(k_reg + 1'b1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        k_reg     <= k_next;
        pivot_reg <= pivot_next;
        lval_reg  <= lval_next;
        rval_reg  <= rval_next;
        out_reg   <= out_next;
    end

endmodule

/* rtl/core/quicksort_engine_unit.sv */
// quicksort_engine_unit: top level of the quicksort engine.
// Depends on qse_pkg, qse_ram and qse_seq.

// Items are loaded one per cycle into a 64-entry store; further items of a set
// are dropped and every result of that set then carries overflow. The item
// marked last starts an in-place quicksort (first element as pivot) run by
// one sequencer with a single comparator and a one-port-read store RAM: each
// compare reads an element and then compares it with the pivot, each swap is
// two writes, and each range is popped, its pivot fetched, the pivot written
// back and its parts pushed; the number of compares grows quadratically for
// presorted data. Each result is read, registered and held until m_ready
// takes it; s_ready stays low from the last item until the final result is
// taken. No clearing pass is needed after reset.
module quicksort_engine_unit
    import qse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  qse_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output qse_out_t m_data
);

    qse_mem_ctl_t     st_ctl;
    qse_mem_ctl_t     sk_ctl;
    logic [VAL_W-1:0] st_wdata, st_rdata;
    logic [RNG_W-1:0] sk_wdata, sk_rdata;

    qse_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .st_ctl   (st_ctl),
        .st_wdata (st_wdata),
        .st_rdata (st_rdata),
        .sk_ctl   (sk_ctl),
        .sk_wdata (sk_wdata),
        .sk_rdata (sk_rdata)
    );

    qse_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (st_ctl.we),
        .waddr (st_ctl.waddr),
        .wdata (st_wdata),
        .raddr (st_ctl.raddr),
        .rdata (st_rdata)
    );

    qse_ram #(
        .WIDTH (RNG_W),
        .DEPTH (DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (sk_ctl.we),
        .waddr (sk_ctl.waddr),
        .wdata (sk_wdata),
        .raddr (sk_ctl.raddr),
        .rdata (sk_rdata)
    );

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result item is pending");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last) |=> !s_ready)
        else $error("input still ready after the last item of a set");

    a_end_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.end_of_run) |=> !m_valid)
        else $error("result item after the end of a run");

endmodule
